// ===== rtl/core/utf8_to_gb2312_glyph_lookup_defines.svh =====
// Assertion macros used by the lookup block's top-level RTL file.
`ifndef UTF8_TO_GB2312_GLYPH_LOOKUP_DEFINES_SVH
`define UTF8_TO_GB2312_GLYPH_LOOKUP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on clk, quiet while rst is high.
`define U2G_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, clocked on clk, quiet while rst is high.
`define U2G_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define U2G_ASSERT_IMPLY(lbl, ante, cons, msg)
`define U2G_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/u2g_pkg.sv =====
// Types, constants and sizes for the UTF-8 to GB2312 glyph lookup.
package u2g_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int GLYPH_SIZE  = 32;

  localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Signed search bound width: holds -1 and the sum of two indices.
  localparam int BOUND_W  = TABLE_AW + 2;
  localparam int CNT_W    = 14;
  localparam int IDXIN_W  = 13;
  localparam int CMP_W    = (BOUND_W > CNT_W + 1) ? BOUND_W : CNT_W + 1;
  localparam int ENTRY_W  = 32;
  localparam int GLYPH_IDX_W = 12;
  localparam int OFS_W    = 17;
  localparam int OFS_PROD_W  = GLYPH_IDX_W + 8;

  localparam logic [7:0] UTF8_LEAD_MIN = 8'hE0;
  localparam logic [7:0] UTF8_LEAD_MAX = 8'hEF;
  localparam logic [7:0] ROW_FIRST     = 8'hB0;
  localparam logic [7:0] ROW_LAST      = 8'hD7;
  localparam logic [7:0] CELL_FIRST    = 8'hA1;
  localparam logic [7:0] CELL_LAST     = 8'hFE;
  localparam logic [GLYPH_IDX_W-1:0] CELLS_PER_ROW = GLYPH_IDX_W'(94);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic REG_FONTS_READY = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [12:0] entry_index;
    logic [15:0] entry_unicode;
    logic [15:0] entry_gb;
  } item_t;

  typedef struct packed {
    logic [15:0] gb_code;
    logic        glyph_valid;
    logic [16:0] glyph_offset;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_INDEX,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/u2g_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module u2g_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/utf8_to_gb2312_glyph_lookup.sv =====
// UTF-8 to GB2312 lookup: table store, binary search sequencer and glyph addressing.
//
// Usage. An item is taken when start is high and busy is low. A load item
// (kind 0) writes {entry_unicode, entry_gb} at entry_index and gives no
// result; busy stays low, so items may follow every cycle. A lookup
// item (kind 1) decodes byte0..byte2 and binary-searches the first
// entry_count table entries, one probe per cycle through a single compare and
// bound-update unit fed by the table RAM's registered read port.
// Steps of a lookup: the acceptance cycle issues the first read, then the
// probe steps run, a glyph index step follows on any hit, a scaling step
// when the code is level 1, then the done step, in which done strobes with
// result. A lead byte outside E0..EF, a zero continuation byte, code point
// zero, an empty table and fonts_ready low skip the probe and glyph steps; a
// miss skips the glyph steps. busy is high from the cycle after acceptance to
// the done cycle inclusive. The result is valid for the single cycle that
// done is high; the receiver cannot stall. The user must write configuration
// over the APB port only while idle; the block does not enforce this. Registers:
// 0x0 fonts_ready, 0x4 entry_count (the search caps it at the table depth).
// Reset (rst, synchronous) clears the sequencer and both registers; the table
// contents are undefined until loaded and no clearing pass is made.
`include "utf8_to_gb2312_glyph_lookup_defines.svh"

module utf8_to_gb2312_glyph_lookup
  import u2g_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic             fonts_ready;
  logic [CNT_W-1:0] entry_count;

  logic [15:0]               cp;
  logic signed [BOUND_W-1:0] lo, hi, mid;
  logic [15:0]               gb;
  logic                      glyph_ok;
  logic [GLYPH_IDX_W-1:0]    glyph_idx;
  logic [OFS_W-1:0]          offset;

  logic                 ram_we;
  logic [TABLE_AW-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                      accept, lookup_go, utf_ok, search_go;
  logic [15:0]               cp_dec;
  logic [CMP_W-1:0]          count_ext, count_sat;
  logic signed [BOUND_W-1:0] hi_init, mid_init;
  logic [15:0]               rd_cp, rd_gb;
  logic                      hit, less, miss_end;
  logic signed [BOUND_W-1:0] lo_next, hi_next, mid_next;
  logic [7:0]                row_off, cell_off;
  logic                      in_range;
  logic [GLYPH_IDX_W-1:0]    glyph_idx_next;
  logic [OFS_PROD_W-1:0]     ofs_prod;
  logic                      cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fonts_ready <= 1'b0;
      entry_count <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FONTS_READY: fonts_ready <= pwdata[0];
        REG_ENTRY_COUNT: entry_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FONTS_READY: prdata = {31'b0, fonts_ready};
      REG_ENTRY_COUNT: prdata = {{(32-CNT_W){1'b0}}, entry_count};
      default:         prdata = '0;
    endcase
  end

  // Item acceptance and decode
  assign accept    = start && !busy;
  assign lookup_go = accept && (item.kind == KIND_LOOKUP);

  assign utf_ok = (item.byte0 >= UTF8_LEAD_MIN) && (item.byte0 <= UTF8_LEAD_MAX) &&
                  (item.byte1 != 8'h00) && (item.byte2 != 8'h00);
  assign cp_dec = utf_ok ? {item.byte0[3:0], item.byte1[5:0], item.byte2[5:0]} : 16'h0000;

  assign count_ext = CMP_W'(entry_count);
  assign count_sat = (count_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : count_ext;
  assign hi_init   = $signed(BOUND_W'(count_sat)) - BOUND_W'(1);
  assign mid_init  = hi_init >>> 1;
  assign search_go = fonts_ready && (cp_dec != 16'h0000) && (hi_init >= 0);

  // Table store
  assign ram_we    = accept && (item.kind == KIND_LOAD) &&
                     (CMP_W'(item.entry_index) < CMP_W'(TABLE_DEPTH));
  assign ram_waddr = TABLE_AW'(item.entry_index);
  assign ram_raddr = (state == ST_IDLE) ? mid_init[TABLE_AW-1:0] : mid_next[TABLE_AW-1:0];

  u2g_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item.entry_unicode, item.entry_gb}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared probe unit: compare, narrow the bounds, form the next midpoint
  assign rd_cp    = ram_rdata[31:16];
  assign rd_gb    = ram_rdata[15:0];
  assign hit      = (rd_cp == cp);
  assign less     = (rd_cp < cp);
  assign lo_next  = less ? (mid + BOUND_W'(1)) : lo;
  assign hi_next  = less ? hi : (mid - BOUND_W'(1));
  assign miss_end = (lo_next > hi_next);
  assign mid_next = (lo_next + hi_next) >>> 1;

  // Glyph addressing
  assign row_off  = gb[15:8] - ROW_FIRST;
  assign cell_off = gb[7:0] - CELL_FIRST;
  assign in_range = (gb[15:8] >= ROW_FIRST) && (gb[15:8] <= ROW_LAST) &&
                    (gb[7:0] >= CELL_FIRST) && (gb[7:0] <= CELL_LAST);
  assign glyph_idx_next = GLYPH_IDX_W'(row_off[5:0]) * CELLS_PER_ROW +
                          GLYPH_IDX_W'(cell_off[6:0]);
  assign ofs_prod = OFS_PROD_W'(glyph_idx) * OFS_PROD_W'(GLYPH_SIZE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (lookup_go) begin
          state_next = search_go ? ST_PROBE : ST_DONE;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          state_next = ST_INDEX;
        end else if (miss_end) begin
          state_next = ST_DONE;
        end
      end
      ST_INDEX: state_next = in_range ? ST_SCALE : ST_DONE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    done   = 1'b0;
    result = '{gb_code: gb, glyph_valid: glyph_ok, glyph_offset: offset};
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (lookup_go) begin
          cp       <= cp_dec;
          lo       <= '0;
          hi       <= hi_init;
          mid      <= mid_init;
          gb       <= 16'h0000;
          glyph_ok <= 1'b0;
          offset   <= '0;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          gb <= rd_gb;
        end else begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
        end
      end
      ST_INDEX: begin
        glyph_idx <= glyph_idx_next;
        glyph_ok  <= in_range;
      end
      ST_SCALE: offset <= ofs_prod[OFS_W-1:0];
      default: ;
    endcase
  end

  `U2G_ASSERT_NEXT(a_lookup_busy, lookup_go, busy, "accepted lookup did not raise busy")
  `U2G_ASSERT_NEXT(a_load_free, accept && (item.kind == KIND_LOAD), !busy,
                   "load transaction left the block busy")
  `U2G_ASSERT_NEXT(a_done_single, done, !done && !busy, "done strobe lasted more than a cycle")
  `U2G_ASSERT_IMPLY(a_probe_bounds, state == ST_PROBE, (lo <= mid) && (mid <= hi),
                    "probe midpoint outside search bounds")
  `U2G_ASSERT_IMPLY(a_no_glyph_zero, done && !result.glyph_valid,
                    result.glyph_offset == '0, "glyph offset set without a valid glyph")

endmodule
